// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: label");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== rtl/swmm_pkg.sv =====
package swmm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int CFG_W          = 7;
  localparam int CFG_RESET      = 3;
  localparam int WINDOW_MAX_DEF = 64;

  // Partial min/max of a window walk, accumulated from cell 0 upward.
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
  } token_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

endpackage

// ===== rtl/swmm_cell.sv =====
module swmm_cell
  import swmm_pkg::*;
#(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift_en,
  input  logic signed [SAMPLE_W-1:0] shift_in,
  output logic signed [SAMPLE_W-1:0] shift_out,
  input  logic                       advance,
  input  logic [CNT_W-1:0]           win,
  input  token_t                     tin,
  output token_t                     tout,
  output token_t                     res
);

  logic signed [SAMPLE_W-1:0] held;
  logic                       tv;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W-1:0] hi;
  logic signed [SAMPLE_W-1:0] cur;
  logic                       last;

  // The sample being loaded counts as held for a token entering this cycle.
  assign cur  = shift_en ? shift_in : held;
  assign last = (win == CNT_W'(IDX + 1));

  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= 1'b0;
    end else if (advance) begin
      tv <= tin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lo <= (cur < tin.lo) ? cur : tin.lo;
      hi <= (cur > tin.hi) ? cur : tin.hi;
    end
  end

  assign shift_out = held;

  // Pass the token on unless this cell closes the window.
  assign tout.valid = tv & ~last;
  assign tout.lo    = lo;
  assign tout.hi    = hi;

  assign res.valid = tv & last;
  assign res.lo    = res.valid ? lo : '0;
  assign res.hi    = res.valid ? hi : '0;

endmodule

// ===== rtl/sliding_window_min_max.sv =====
// Sliding window minimum and maximum over a stream of signed 32-bit samples.
// Samples shift into a chain of WINDOW_MAX cells, newest in cell 0. When the
// sequence holds at least window_size samples (0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX), a min/max token walks from cell 0 one cell
// per cycle and the result is registered once it reaches the window's last
// cell and the output can take it. While a token walks, no new sample is
// taken until its result has been registered; a sample that yields no result
// does not hold up the input. new_sequence restarts the fill count; held
// samples are never cleared, and no clearing pass runs after reset.
`include "assert_macros.svh"

module sliding_window_min_max
  import swmm_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       new_sequence,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] window_min,
  output logic signed [SAMPLE_W-1:0] window_max
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] window_size;
  logic [EXT_W-1:0] size_ext;
  logic [CNT_W-1:0] win;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_base;
  logic [CNT_W-1:0] fill_next;
  logic             start;
  logic             accept;
  logic             advance;
  logic             done;
  logic             out_busy;
  logic             capture;
  state_t           state;
  state_t           state_next;
  token_t           head;
  token_t           res_sel;

  logic signed [SAMPLE_W-1:0] chain_s [WINDOW_MAX+1];
  token_t                     chain_t [WINDOW_MAX+1];
  token_t                     res     [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]      res_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= CFG_W'(CFG_RESET);
    end else if (cfg_write) begin
      window_size <= cfg_data;
    end
  end

  always_comb begin
    size_ext = EXT_W'(window_size);
    if (size_ext == '0) begin
      win = CNT_W'(1);
    end else if (size_ext > EXT_W'(WINDOW_MAX)) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = size_ext[CNT_W-1:0];
    end
  end

  assign accept    = in_valid & in_ready;
  assign fill_base = new_sequence ? '0 : fill;
  assign fill_next = (fill_base < CNT_W'(WINDOW_MAX)) ? fill_base + CNT_W'(1) : fill_base;
  assign start     = (fill_next >= win);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign out_busy = out_valid & ~out_ready;
  assign capture  = done & ~out_busy;
  // Freeze the walk while the finished result cannot be stored.
  assign advance  = ~(done & out_busy);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && start) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (capture) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign head.valid = accept & start;
  assign head.lo    = sample;
  assign head.hi    = sample;
  assign chain_s[0] = sample;
  assign chain_t[0] = head;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swmm_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_en  (accept),
      .shift_in  (chain_s[i]),
      .shift_out (chain_s[i+1]),
      .advance   (advance),
      .win       (win),
      .tin       (chain_t[i]),
      .tout      (chain_t[i+1]),
      .res       (res[i])
    );
    assign res_v[i] = res[i].valid;
  end

  // At most one cell closes the window, so an OR picks its result.
  always_comb begin
    res_sel = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      res_sel = res_sel | res[i];
    end
  end
  assign done = res_sel.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      window_min <= res_sel.lo;
      window_max <= res_sel.hi;
    end
  end

  `ASSERT_ALWAYS(a_one_result, clk, rst, $onehot0(res_v))
  `ASSERT_NEVER(a_idle_no_result, clk, rst, (state == ST_IDLE) && done)
  `ASSERT_ALWAYS(a_capture_shows, clk, rst, capture |=> out_valid && (window_min <= window_max))
  `ASSERT_ALWAYS(a_walk_blocks, clk, rst, (state == ST_WALK) |-> !in_ready)

endmodule
